[rtl/frbbm_pkg.sv]
// Package for the fan relay controller with break-before-make interlock.
// Holds command codes, field widths, result bit positions and the relay decode.
// No dependencies.
package frbbm_pkg;

    // Highest speed step; the relay and speed field widths are fixed for three steps
    localparam int unsigned SPEED_COUNT = 3;

    localparam int unsigned SPEED_W     = 2;
    localparam int unsigned RELAY_W     = 3;
    localparam int unsigned BREAK_W     = 16;
    localparam int unsigned CODE_W      = 8;
    localparam int unsigned VALUE_W     = 8;

    // Break time after reset, in ticks
    localparam logic [BREAK_W-1:0] BREAK_RESET = 16'd100;

    // Item kinds carried on the input tuser
    localparam logic OP_COMMAND = 1'b0;
    localparam logic OP_TICK    = 1'b1;

    // Command codes
    localparam logic [CODE_W-1:0] CODE_SET_SPEED = 8'h01;
    localparam logic [CODE_W-1:0] CODE_SET_OSC   = 8'h02;
    localparam logic [CODE_W-1:0] CODE_POWER_OFF = 8'h03;

    // Result status codes
    localparam logic STATUS_OK     = 1'b0;
    localparam logic STATUS_REJECT = 1'b1;

    // Result tdata bit positions, lowest first
    localparam int unsigned OUT_RELAY_LO   = 0;
    localparam int unsigned OUT_RELAY_HI   = 2;
    localparam int unsigned OUT_OSC_RELAY  = 3;
    localparam int unsigned OUT_SPEED_LO   = 4;
    localparam int unsigned OUT_SPEED_HI   = 5;
    localparam int unsigned OUT_OSC        = 6;
    localparam int unsigned OUT_CHANGED    = 7;
    localparam int unsigned OUT_DATA_W     = 8;

    // Controller state
    typedef struct packed {
        logic [SPEED_W-1:0] wanted_speed;
        logic               wanted_osc;
        logic [SPEED_W-1:0] applied_speed;
        logic               applied_osc;
        logic               pending;
        logic [BREAK_W-1:0] countdown;
    } ctrl_state_t;

    // One-hot relay drive for an applied speed; zero when off
    function automatic logic [RELAY_W-1:0] relay_decode(input logic [SPEED_W-1:0] speed);
        logic [RELAY_W-1:0] bits;
        bits = '0;
        if (speed != '0) begin
            bits[speed - 2'd1] = 1'b1;
        end
        return bits;
    endfunction

endpackage

[rtl/fan_relay_break_before_make_top.sv]
// Fan relay controller with break-before-make interlock: top level.
// Input register, single-pass state update, result register. Uses frbbm_pkg.
// Each accepted item passes through the input register, then the result register.
// Throughput: one item per cycle while results are taken; the state update is one
// pass of short logic between the two registers, so items follow back to back.
// Reset: rst_n clears all control state, break time returns to 100 ticks.
module fan_relay_break_before_make_top
    import frbbm_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    // Break time register write
    input  logic        cfg_we,
    input  logic [15:0] cfg_wdata,
    // Input items
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [7:0] command_code, [15:8] command_value
    input  logic        s_axis_tuser,   // [0] operation
    // Result items
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [2:0] speed_relay_bits, [3] osc_relay_drive,
                                        // [5:4] present_speed, [6] present_oscillation,
                                        // [7] changed
    output logic        m_axis_tuser    // [0] status
);

    logic [BREAK_W-1:0] break_time_reg;

    logic               in_valid_reg;
    logic               in_op_reg;
    logic [CODE_W-1:0]  in_code_reg;
    logic [VALUE_W-1:0] in_value_reg;

    logic                  out_valid_reg;
    logic [OUT_DATA_W-1:0] out_data_reg;
    logic                  out_status_reg;

    ctrl_state_t state_reg;
    ctrl_state_t state_next;
    ctrl_state_t cmd_state;

    logic                  cmd_ok;
    logic                  chg;
    logic                  out_advance;
    logic                  in_advance;
    logic [OUT_DATA_W-1:0] out_data_next;
    logic                  out_status_next;

    // Handshake: result stage moves when empty or taken, input stage when result moves
    assign out_advance   = !out_valid_reg || m_axis_tready;
    assign in_advance    = !in_valid_reg || out_advance;
    assign s_axis_tready = in_advance;

    // Hold the break time
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            break_time_reg <= BREAK_RESET;
        end
        else if (cfg_we)
        begin
            break_time_reg <= cfg_wdata;
        end
    end

    // Capture the input item
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (in_advance)
        begin
            in_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_advance && s_axis_tvalid)
        begin
            in_op_reg    <= s_axis_tuser;
            in_code_reg  <= s_axis_tdata[CODE_W-1:0];
            in_value_reg <= s_axis_tdata[CODE_W+VALUE_W-1:CODE_W];
        end
    end

    // Decode the command and apply it to the wanted settings
    always_comb
    begin
        cmd_state = state_reg;
        cmd_ok    = 1'b0;
        unique case (in_code_reg)
            CODE_SET_SPEED:
            begin
                cmd_ok = (in_value_reg <= VALUE_W'(SPEED_COUNT));
                cmd_state.wanted_speed = in_value_reg[SPEED_W-1:0];
            end
            CODE_SET_OSC:
            begin
                cmd_ok = (in_value_reg <= 8'd1);
                cmd_state.wanted_osc = in_value_reg[0];
            end
            CODE_POWER_OFF:
            begin
                cmd_ok = (in_value_reg == '0);
                cmd_state.wanted_speed = '0;
                cmd_state.wanted_osc   = 1'b0;
            end
            default:
            begin
                cmd_ok = 1'b0;
            end
        endcase
    end

    // Work out the next state and the result for the registered item
    always_comb
    begin
        state_next      = state_reg;
        chg             = 1'b0;
        out_status_next = STATUS_OK;
        if (in_op_reg == OP_TICK)
        begin
            // Count down the break; close the newest wanted speed at expiry
            if (state_reg.pending)
            begin
                if (state_reg.countdown > 16'd1)
                begin
                    state_next.countdown = state_reg.countdown - 16'd1;
                end
                else
                begin
                    state_next.countdown = '0;
                    state_next.pending   = 1'b0;
                    if (state_reg.wanted_speed != '0)
                    begin
                        state_next.applied_speed = state_reg.wanted_speed;
                        chg = 1'b1;
                    end
                end
            end
        end
        else if (!cmd_ok)
        begin
            out_status_next = STATUS_REJECT;
        end
        else
        begin
            state_next = cmd_state;
            // Oscillation relay follows at once
            if (cmd_state.applied_osc != cmd_state.wanted_osc)
            begin
                state_next.applied_osc = cmd_state.wanted_osc;
                chg = 1'b1;
            end
            if (cmd_state.wanted_speed == '0)
            begin
                // Off: cancel any break and open all speed relays
                state_next.pending   = 1'b0;
                state_next.countdown = '0;
                if (cmd_state.applied_speed != '0)
                begin
                    state_next.applied_speed = '0;
                    chg = 1'b1;
                end
            end
            else if (!cmd_state.pending && cmd_state.applied_speed != cmd_state.wanted_speed)
            begin
                // New speed: open all speed relays and start the break
                state_next.applied_speed = '0;
                state_next.pending       = 1'b1;
                state_next.countdown     = break_time_reg;
            end
        end

        out_data_next = '0;
        out_data_next[OUT_RELAY_HI:OUT_RELAY_LO] = relay_decode(state_next.applied_speed);
        out_data_next[OUT_OSC_RELAY]             = state_next.applied_osc;
        out_data_next[OUT_SPEED_HI:OUT_SPEED_LO] = state_next.applied_speed;
        out_data_next[OUT_OSC]                   = state_next.applied_osc;
        out_data_next[OUT_CHANGED]               = chg;
    end

    // Advance the controller state as each item leaves the input stage
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= '0;
        end
        else if (in_valid_reg && out_advance)
        begin
            state_reg <= state_next;
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_advance)
        begin
            out_valid_reg <= in_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_advance && in_valid_reg)
        begin
            out_data_reg   <= out_data_next;
            out_status_reg <= out_status_next;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_status_reg;

endmodule

[rtl/frbbm_checker.sv]
// Port-level checks for the fan relay controller result stream.
// Uses frbbm_pkg for result bit positions; bound to fan_relay_break_before_make_top.
module frbbm_checker
    import frbbm_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       m_axis_tvalid,
    input logic       m_axis_tready,
    input logic [7:0] m_axis_tdata,
    input logic       m_axis_tuser
);

    // Never more than one speed relay closed
    a_relay_onehot: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> $onehot0(m_axis_tdata[OUT_RELAY_HI:OUT_RELAY_LO]))
        else $error("more than one speed relay closed");

    // Relay drive agrees with the applied speed
    a_relay_speed: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |->
            ((m_axis_tdata[OUT_SPEED_HI:OUT_SPEED_LO] == 2'd0) ==
             (m_axis_tdata[OUT_RELAY_HI:OUT_RELAY_LO] == 3'd0)))
        else $error("speed relay drive disagrees with present speed");

    // Oscillation relay tracks the applied oscillation
    a_osc_match: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[OUT_OSC_RELAY] == m_axis_tdata[OUT_OSC]))
        else $error("oscillation relay disagrees with present oscillation");

    // A rejected command never raises a notify
    a_reject_quiet: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser == STATUS_REJECT) |-> !m_axis_tdata[OUT_CHANGED])
        else $error("rejected command reported a change");

    // A stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |=>
            (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
        else $error("stalled result changed");

endmodule

bind fan_relay_break_before_make_top frbbm_checker u_frbbm_checker (.*);
